@@ sv/epwo_pkg.sv @@
// ----------------------------------------------------------------------------
// epwo_pkg
// Shared types, constants and the divider step for the wheel odometry block.
// ----------------------------------------------------------------------------
package epwo_pkg;

  // Field widths fixed by the item formats
  localparam int unsigned EdgeTimeW = 48;
  localparam int unsigned SpeedW    = 16;
  localparam int unsigned TickW     = 16;
  localparam int unsigned BaseW     = 12;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 1;

  // Divider: 26-bit dividend covers 65535 * 1000, two quotient bits per cycle
  localparam int unsigned NumW      = 26;
  localparam int unsigned DivSteps  = NumW / 2;
  localparam int unsigned DivCntW   = $clog2(DivSteps);
  localparam int unsigned ScaleK    = 1000;

  localparam logic [SpeedW-1:0] SpeedMax = {SpeedW{1'b1}};
  localparam logic [SpeedW-1:0] RateMax  = 16'h7FFF;
  localparam logic [SpeedW-1:0] RateMin  = 16'h8000;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_TICK_DIST  = 1'b0,
    REG_WHEEL_BASE = 1'b1
  } cfg_reg_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SPD_LD,
    S_SPD_DIV,
    S_SPD_WB,
    S_ANG_LD,
    S_ANG_DIV,
    S_ANG_WB,
    S_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic                 cmd;
    logic [EdgeTimeW-1:0] edge_time_us;
  } in_item_t;

  typedef struct packed {
    logic        [SpeedW-1:0]    left_speed_mm_s;
    logic        [SpeedW-1:0]    right_speed_mm_s;
    logic        [SpeedW-1:0]    mean_speed_mm_s;
    logic signed [SpeedW-1:0]    angular_rate_mrad_s;
    logic        [EdgeTimeW-1:0] sample_time_us;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic spd_load;
    logic div_step;
    logic spd_wb;
    logic ang_load;
    logic ang_wb;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [NumW-1:0] quo;
  } div_pair_t;

  // One restoring division step: shifts one dividend bit in, one quotient bit out
  function automatic div_pair_t div_step(input logic [NumW-1:0] rem,
                                         input logic [NumW-1:0] quo,
                                         input logic [NumW-1:0] den);
    logic [NumW:0] trial;
    div_pair_t     res;
    trial = {rem, quo[NumW-1]};
    res.quo = {quo[NumW-2:0], 1'b0};
    if (trial >= {1'b0, den}) begin
      trial = trial - {1'b0, den};
      res.quo[0] = 1'b1;
    end
    res.rem = trial[NumW-1:0];
    return res;
  endfunction

endpackage

@@ sv/epwo_ctrl.sv @@
// ----------------------------------------------------------------------------
// epwo_ctrl
// Sequencer: speed division, angular-rate division, then result hand-off.
// ----------------------------------------------------------------------------
module epwo_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  epwo_pkg::dp_stat_t  stat_i,
  output epwo_pkg::dp_cmd_t   cmd_o
);

  epwo_pkg::ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= epwo_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      epwo_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = epwo_pkg::S_SPD_LD;
        end
      end
      epwo_pkg::S_SPD_LD: begin
        cmd_o.spd_load = 1'b1;
        state_d = epwo_pkg::S_SPD_DIV;
      end
      epwo_pkg::S_SPD_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = epwo_pkg::S_SPD_WB;
      end
      epwo_pkg::S_SPD_WB: begin
        cmd_o.spd_wb = 1'b1;
        state_d = epwo_pkg::S_ANG_LD;
      end
      epwo_pkg::S_ANG_LD: begin
        cmd_o.ang_load = 1'b1;
        state_d = epwo_pkg::S_ANG_DIV;
      end
      epwo_pkg::S_ANG_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = epwo_pkg::S_ANG_WB;
      end
      epwo_pkg::S_ANG_WB: begin
        cmd_o.ang_wb = 1'b1;
        state_d = epwo_pkg::S_OUT;
      end
      epwo_pkg::S_OUT: begin
        // wait for the output register to free up
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = epwo_pkg::S_IDLE;
        end
      end
      default: state_d = epwo_pkg::S_IDLE;
    endcase
  end

  // Assertions
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == epwo_pkg::S_IDLE && in_valid_i) |=> state_q == epwo_pkg::S_SPD_LD)
    else $error("accepted beat did not start the speed division");

  a_div_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == epwo_pkg::S_SPD_DIV && !stat_i.div_last) |=>
      state_q == epwo_pkg::S_SPD_DIV)
    else $error("speed division left early");

  a_out_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == epwo_pkg::S_OUT && !stat_i.out_free) |=> state_q == epwo_pkg::S_OUT)
    else $error("result dropped while output register busy");

endmodule

@@ sv/epwo_dp.sv @@
// ----------------------------------------------------------------------------
// epwo_dp
// Datapath: edge times, wheel speeds, shared multiplier and radix-4 divider,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module epwo_dp #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [epwo_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [epwo_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  epwo_pkg::in_item_t                  in_data_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output epwo_pkg::out_item_t                 out_data_o,
  input  epwo_pkg::dp_cmd_t                   cmd_i,
  output epwo_pkg::dp_stat_t                  stat_o
);

  localparam int unsigned NumW   = epwo_pkg::NumW;
  localparam int unsigned SpeedW = epwo_pkg::SpeedW;

  logic [epwo_pkg::TickW-1:0] tick_q;
  logic [epwo_pkg::BaseW-1:0] base_q;

  logic [TIME_BITS-1:0] left_time_q, right_time_q;
  logic [TIME_BITS-1:0] now_q, period_q, now_in;
  logic                 sel_q;
  logic [SpeedW-1:0]    left_q, right_q, rate_q;

  logic [NumW-1:0]              rem_q, quo_q, den_q;
  logic [epwo_pkg::DivCntW-1:0] cnt_q;
  epwo_pkg::div_pair_t          step1, step2;

  logic [SpeedW-1:0] mul_a, diff_mag, speed_new, rate_new;
  logic [NumW-1:0]   product;
  logic              neg;
  logic [SpeedW:0]   sum;

  logic                 out_valid_q;
  epwo_pkg::out_item_t  out_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= 16'd8830;
      base_q <= 12'd100;
    end else if (cfg_we_i) begin
      unique case (epwo_pkg::cfg_reg_e'(cfg_idx_i))
        epwo_pkg::REG_TICK_DIST:  tick_q <= cfg_wdata_i[epwo_pkg::TickW-1:0];
        epwo_pkg::REG_WHEEL_BASE: base_q <= cfg_wdata_i[epwo_pkg::BaseW-1:0];
        default: ;
      endcase
    end
  end

  // Per-wheel edge time and period
  assign now_in = TIME_BITS'(in_data_i.edge_time_us);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_time_q  <= '0;
      right_time_q <= '0;
    end else if (cmd_i.load_item) begin
      if (in_data_i.cmd) right_time_q <= now_in;
      else               left_time_q  <= now_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      sel_q    <= in_data_i.cmd;
      now_q    <= now_in;
      period_q <= now_in - (in_data_i.cmd ? right_time_q : left_time_q);
    end
  end

  // Speed difference magnitude and sign
  assign neg      = left_q > right_q;
  assign diff_mag = neg ? (left_q - right_q) : (right_q - left_q);

  // Shared constant multiplier: operand * 1000
  assign mul_a   = cmd_i.ang_load ? diff_mag : tick_q;
  assign product = NumW'(mul_a) * NumW'(epwo_pkg::ScaleK);

  // Radix-4 restoring divider: two quotient bits per cycle
  assign step1 = epwo_pkg::div_step(rem_q, quo_q, den_q);
  assign step2 = epwo_pkg::div_step(step1.rem, step1.quo, den_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.spd_load || cmd_i.ang_load) begin
      quo_q <= product;
      rem_q <= '0;
      cnt_q <= '0;
      den_q <= cmd_i.ang_load ? NumW'(base_q) : period_q[NumW-1:0];
    end else if (cmd_i.div_step) begin
      quo_q <= step2.quo;
      rem_q <= step2.rem;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign stat_o.div_last = cnt_q == epwo_pkg::DivCntW'(epwo_pkg::DivSteps - 1);

  // Speed saturation: zero period, long period, or quotient overflow
  always_comb begin
    if (period_q == '0) begin
      speed_new = epwo_pkg::SpeedMax;
    end else if (|period_q[TIME_BITS-1:NumW]) begin
      speed_new = '0;
    end else if (|quo_q[NumW-1:SpeedW]) begin
      speed_new = epwo_pkg::SpeedMax;
    end else begin
      speed_new = quo_q[SpeedW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
    end else if (cmd_i.spd_wb) begin
      if (sel_q) right_q <= speed_new;
      else       left_q  <= speed_new;
    end
  end

  // Angular rate: sign, saturation and the zero-base case
  always_comb begin
    if (diff_mag == '0) begin
      rate_new = '0;
    end else if (base_q == '0) begin
      rate_new = neg ? epwo_pkg::RateMin : epwo_pkg::RateMax;
    end else if (neg) begin
      rate_new = (|quo_q[NumW-1:SpeedW-1]) ? epwo_pkg::RateMin : -quo_q[SpeedW-1:0];
    end else begin
      rate_new = (|quo_q[NumW-1:SpeedW-1]) ? epwo_pkg::RateMax : quo_q[SpeedW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ang_wb) rate_q <= rate_new;
  end

  // Output register
  assign sum = {1'b0, left_q} + {1'b0, right_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.left_speed_mm_s     <= left_q;
      out_q.right_speed_mm_s    <= right_q;
      out_q.mean_speed_mm_s     <= sum[SpeedW:1];
      out_q.angular_rate_mrad_s <= rate_q;
      out_q.sample_time_us      <= epwo_pkg::EdgeTimeW'(now_q);
    end
  end

  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

  // Assertions
  a_mean_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.mean_speed_mm_s ==
      SpeedW'(({1'b0, out_q.left_speed_mm_s} + {1'b0, out_q.right_speed_mm_s}) >> 1))
    else $error("mean speed does not match wheel speeds");

  a_zero_period_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.spd_wb && period_q == '0) |=>
      (sel_q ? right_q : left_q) == epwo_pkg::SpeedMax)
    else $error("zero period did not saturate speed");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_step && stat_o.div_last) |-> !$past(cmd_i.div_step && stat_o.div_last))
    else $error("divider ran past its last step");

endmodule

@@ sv/encoder_period_wheel_odometry.sv @@
// ----------------------------------------------------------------------------
// encoder_period_wheel_odometry
// Differential-drive odometry from per-wheel encoder edge periods.
// ----------------------------------------------------------------------------
// One edge at a time: in_stall_o stays high from acceptance until the result
//   is loaded into a free output register, after the speed division and then
//   the angular-rate division on the shared radix-4 divider.
// The output register holds a result while the next edge is taken.
// Reset clears edge times and speeds to zero, tick distance to 8830 um
//   and wheel base to 100 mm.
module encoder_period_wheel_odometry #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [epwo_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [epwo_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  epwo_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output epwo_pkg::out_item_t            out_data_o
);

  epwo_pkg::dp_cmd_t  cmd;
  epwo_pkg::dp_stat_t stat;

  // Sequencer
  epwo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Arithmetic and storage
  epwo_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

@@ sim/tb_encoder_period_wheel_odometry.sv @@
// ----------------------------------------------------------------------------
// tb_encoder_period_wheel_odometry
// Self-checking bench for the wheel odometry block. Encoder edge beats for
// both wheels are sent with random gaps while results are taken with random
// stalls. An in-bench odometry predictor tracks edge times, wheel speeds and
// register values and checks every result beat field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// Expected odometry for each accepted edge, plus the in-order result check
class odometry_checker;
  logic [15:0]         tick_um;
  logic [11:0]         base_mm;
  logic [47:0]         left_last;
  logic [47:0]         right_last;
  logic [15:0]         left_spd;
  logic [15:0]         right_spd;
  epwo_pkg::out_item_t pending_odometry[$];
  int unsigned         edges;
  int unsigned         results;
  int unsigned         failures;
  int unsigned         shown;
  int unsigned         speed_sats;
  int unsigned         rate_sats;

  function new();
    tick_um    = 16'd8830;
    base_mm    = 12'd100;
    left_last  = '0;
    right_last = '0;
    left_spd   = '0;
    right_spd  = '0;
    edges      = 0;
    results    = 0;
    failures   = 0;
    shown      = 0;
    speed_sats = 0;
    rate_sats  = 0;
  endfunction

  function void set_reg(epwo_pkg::cfg_reg_e idx, logic [15:0] val);
    case (idx)
      epwo_pkg::REG_TICK_DIST:  tick_um = val;
      epwo_pkg::REG_WHEEL_BASE: base_mm = val[11:0];
      default: ;
    endcase
  endfunction

  // Speed in mm/s from one edge period, saturated
  function logic [15:0] speed_for(logic [47:0] period);
    longint unsigned q;
    if (period == '0) begin
      speed_sats++;
      return 16'hFFFF;
    end
    q = (64'(tick_um) * 64'd1000) / 64'(period);
    if (q > 64'd65535) begin
      speed_sats++;
      return 16'hFFFF;
    end
    return q[15:0];
  endfunction

  // (right - left) * 1000 / base, truncated toward zero, saturated to 16 bits
  function logic [15:0] rate_for(logic [15:0] l, logic [15:0] r);
    logic            neg;
    longint unsigned mag;
    longint unsigned q;
    neg = l > r;
    mag = neg ? 64'(l) - 64'(r) : 64'(r) - 64'(l);
    if (mag == 0) return 16'h0000;
    if (base_mm == '0) begin
      rate_sats++;
      return neg ? epwo_pkg::RateMin : epwo_pkg::RateMax;
    end
    q = (mag * 64'd1000) / 64'(base_mm);
    if (neg) begin
      if (q >= 64'd32768) begin
        rate_sats++;
        return epwo_pkg::RateMin;
      end
      return 16'(64'h10000 - q);
    end
    if (q > 64'd32767) begin
      rate_sats++;
      return epwo_pkg::RateMax;
    end
    return q[15:0];
  endfunction

  function void note_edge(epwo_pkg::in_item_t beat);
    epwo_pkg::out_item_t want;
    logic [47:0]         period;
    if (beat.cmd == 1'b0) begin
      period    = beat.edge_time_us - left_last;
      left_last = beat.edge_time_us;
      left_spd  = speed_for(period);
    end else begin
      period     = beat.edge_time_us - right_last;
      right_last = beat.edge_time_us;
      right_spd  = speed_for(period);
    end
    want.left_speed_mm_s     = left_spd;
    want.right_speed_mm_s    = right_spd;
    want.mean_speed_mm_s     = 16'((17'(left_spd) + 17'(right_spd)) >> 1);
    want.angular_rate_mrad_s = rate_for(left_spd, right_spd);
    want.sample_time_us      = beat.edge_time_us;
    pending_odometry.push_back(want);
    edges++;
  endfunction

  function void check_result(epwo_pkg::out_item_t got);
    epwo_pkg::out_item_t want;
    logic                bad;
    results++;
    if (pending_odometry.size() == 0) begin
      failures++;
      if (shown < 10) begin
        shown++;
        $display("result beat %0d arrived with nothing outstanding: %p", results, got);
      end
      return;
    end
    want = pending_odometry.pop_front();
    bad = (got.left_speed_mm_s != want.left_speed_mm_s) ||
          (got.right_speed_mm_s != want.right_speed_mm_s) ||
          (got.mean_speed_mm_s != want.mean_speed_mm_s) ||
          (got.angular_rate_mrad_s != want.angular_rate_mrad_s) ||
          (got.sample_time_us != want.sample_time_us);
    if (bad) begin
      failures++;
      if (shown < 10) begin
        shown++;
        $display("result %0d exp/act: left %0d/%0d right %0d/%0d mean %0d/%0d",
                 results, want.left_speed_mm_s, got.left_speed_mm_s,
                 want.right_speed_mm_s, got.right_speed_mm_s,
                 want.mean_speed_mm_s, got.mean_speed_mm_s);
        $display("  rate %0d/%0d time %h/%h", want.angular_rate_mrad_s,
                 got.angular_rate_mrad_s, want.sample_time_us, got.sample_time_us);
      end
    end
  endfunction
endclass

module tb_encoder_period_wheel_odometry;

  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned PhaseItems   = 205;
  localparam int unsigned NumPhases    = 8;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  epwo_pkg::cfg_reg_e  cfg_idx_i   = epwo_pkg::REG_TICK_DIST;
  logic [15:0]         cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  epwo_pkg::in_item_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  epwo_pkg::out_item_t out_data_o;

  odometry_checker chk = new();
  bit              send_calm = 1'b0;
  bit              recv_calm = 1'b0;
  int unsigned     stall_left = 0;
  int unsigned     settings_used = 0;
  int unsigned     cycle_count;

  encoder_period_wheel_odometry dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  // Period mix: zero, saturating, mid range, slow, and wrapping
  function automatic logic [47:0] pick_period();
    case ($urandom_range(0, 15))
      0:             return 48'd0;
      1:             return 48'($urandom_range(1, 8));
      2, 3:          return 48'($urandom_range(60, 3000));
      4, 5, 6, 7, 8: return 48'($urandom_range(1000, 100000));
      9, 10:         return 48'($urandom_range(100000, 80000000));
      11:            return 48'({$urandom, $urandom});
      12:            return 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 1000));
      default:       return 48'($urandom_range(100, 20000));
    endcase
  endfunction

  // Result side: take beats, stall a drawn number of cycles before each one
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      chk.check_result(out_data_o);
      stall_left = draw_wait(recv_calm);
    end else if (out_valid_o && stall_left > 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left > 0);
  end

  // Watchdog
  initial begin
    for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++) @(posedge clk_i);
    $display("timeout after %0d cycles", CycleLimit);
    $display("FAILURE");
    $finish;
  end

  // One edge beat: optional gap, then hold until accepted
  task automatic drive_edge(input logic wheel, input logic [47:0] stamp);
    epwo_pkg::in_item_t beat;
    int unsigned        gap;
    beat.cmd          = wheel;
    beat.edge_time_us = stamp;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    chk.note_edge(beat);
  endtask

  // Edge a given period after that wheel's previous edge
  task automatic edge_after(input logic wheel, input logic [47:0] period);
    drive_edge(wheel, (wheel ? chk.right_last : chk.left_last) + period);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (chk.pending_odometry.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write both registers back to back; upper wdata bits of the base are junk
  task automatic write_regs(input logic [15:0] tick, input logic [11:0] base);
    logic [15:0] base_word;
    base_word = {4'($urandom), base};
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= epwo_pkg::REG_TICK_DIST;
    cfg_wdata_i <= tick;
    @(posedge clk_i);
    cfg_idx_i   <= epwo_pkg::REG_WHEEL_BASE;
    cfg_wdata_i <= base_word;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    chk.set_reg(epwo_pkg::REG_TICK_DIST, tick);
    chk.set_reg(epwo_pkg::REG_WHEEL_BASE, base_word);
    settings_used++;
  endtask

  initial begin
    logic [15:0] tick;
    logic [11:0] base;
    logic        wheel;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, first edges, zero and huge periods, wrap
    drive_edge(1'b0, 48'd0);
    drive_edge(1'b1, 48'd0);
    drive_edge(1'b0, 48'hFFFF_FFFF_FFFF);
    drive_edge(1'b1, 48'hFFFF_FFFF_FFFF);
    drive_edge(1'b0, 48'd5);
    drive_edge(1'b1, 48'd3999);
    edge_after(1'b0, 48'd2000);
    edge_after(1'b1, 48'd135);
    edge_after(1'b1, 48'd134);
    drive_edge(1'b0, 48'hAAAA_AAAA_AAAA);
    drive_edge(1'b1, 48'h5555_5555_5555);
    edge_after(1'b0, 48'd1);

    // Zero wheel base: equal, right faster, left faster
    drain();
    write_regs(16'd8830, 12'd0);
    edge_after(1'b1, 48'd1);
    edge_after(1'b0, 48'd100000);
    edge_after(1'b1, 48'd100000);
    edge_after(1'b0, 48'd1);

    // Zero tick distance, smallest base
    drain();
    write_regs(16'd0, 12'd1);
    edge_after(1'b0, 48'd1000);
    edge_after(1'b1, 48'd0);
    edge_after(1'b1, 48'd50);

    // Random phases, each under its own register setting
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      case (p)
        0:       begin tick = 16'd8830;               base = 12'd100;                 end
        1:       begin tick = 16'hFFFF;               base = 12'hFFF;                 end
        2:       begin tick = 16'd1;                  base = 12'd1;                   end
        3:       begin tick = 16'd0;                  base = 12'($urandom);           end
        4:       begin tick = 16'($urandom);          base = 12'd0;                   end
        5:       begin tick = 16'hFFFF;               base = 12'd1;                   end
        6:       begin tick = 16'($urandom);          base = 12'($urandom);           end
        default: begin tick = 16'($urandom_range(4000, 12000));
                       base = 12'($urandom_range(50, 300));                           end
      endcase
      write_regs(tick, base);
      for (int i = 0; i < PhaseItems; i++) begin
        // Redraw idling behavior now and then, with calm stretches
        if (i % 40 == 0) begin
          send_calm = ($urandom_range(0, 3) == 0);
          recv_calm = ($urandom_range(0, 3) == 0);
        end
        // Sender holds off mid-phase until everything is back
        if (p == 6 && i == 100) drain();
        wheel = 1'($urandom);
        if ($urandom_range(0, 31) == 0) drive_edge(wheel, 48'({$urandom, $urandom}));
        else edge_after(wheel, pick_period());
      end
    end

    drain();
    $display("Sent %0d edge beats, checked %0d results under %0d register settings.",
             chk.edges, chk.results, settings_used + 1);
    $display("Saturations hit: %0d on wheel speed, %0d on angular rate; %0d failures.",
             chk.speed_sats, chk.rate_sats, chk.failures);
    if (chk.failures == 0 && chk.pending_odometry.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
